/* src/lop_pkg.sv */
// Package for the lattice order parameter block: widths, constants and the CORDIC angle table.
// It depends on nothing and is used by every module in src.
`timescale 1ns / 1ps
`default_nettype none
package lop_pkg;
  localparam int MaxPoints = 65536;
  localparam int CordicSteps = 16;
  localparam int CntW = 17;
  localparam int SumW = 34;
  localparam logic [31:0] InvSqrt3Q32 = 32'd2479700525;
  localparam logic [33:0] CordicGainQ30 = 34'd652032874;
  localparam logic [23:0] TpuReset = 24'd1048576;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] t;
    unique case (i)
      5'd0: t = 32'h20000000;  5'd1: t = 32'h12E4051E;  5'd2: t = 32'h09FB385B;
      5'd3: t = 32'h051111D4;  5'd4: t = 32'h028B0D43;  5'd5: t = 32'h0145D7E1;
      5'd6: t = 32'h00A2F61E;  5'd7: t = 32'h00517C55;  5'd8: t = 32'h0028BE53;
      5'd9: t = 32'h00145F2F;  5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3; 5'd14: t = 32'h0000A2FA;
      5'd15: t = 32'h0000517D; 5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A30; 5'd19: t = 32'h00000518; 5'd20: t = 32'h0000028C;
      5'd21: t = 32'h00000146; 5'd22: t = 32'h000000A3; 5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000029; 5'd25: t = 32'h00000014; 5'd26: t = 32'h0000000A;
      5'd27: t = 32'h00000005; 5'd28: t = 32'h00000003; 5'd29: t = 32'h00000001;
      5'd30: t = 32'h00000001; default: t = 32'h00000000;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

/* src/lop_cordic_cell.sv */
// One CORDIC micro-rotation cell with a shift set by its step input, registered toward its neighbor.
// Depends on lop_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lop_cordic_cell (
  input  wire logic        clk,
  input  wire logic [4:0]  step,
  input  wire logic        en,
  input  wire logic [33:0] x_in,
  input  wire logic [33:0] y_in,
  input  wire logic [32:0] z_in,
  output logic [33:0]      x_out,
  output logic [33:0]      y_out,
  output logic [32:0]      z_out
);
  import lop_pkg::*;
  logic [33:0] dx, dy;
  logic [32:0] at;
  assign dx = $signed(y_in) >>> step;
  assign dy = $signed(x_in) >>> step;
  assign at = {1'b0, atan_turn(step)};
  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[32]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - at;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + at;
      end
    end
  end
endmodule
`default_nettype wire

/* src/lop_isqrt.sv */
// Magnitude unit: largest r in [0,65536] with (r*n)^2 <= 4*(sc^2+ss^2), one bit per pass.
// Squares are formed by accumulating 34x17 partial products. Depends on lop_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lop_isqrt (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [33:0]       sc,
  input  wire logic [33:0]       ss,
  input  wire logic [16:0]       n,
  output logic                   done,
  output logic [16:0]            mag
);
  import lop_pkg::*;
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_SQA = 6'b000010, S_TRY = 6'b000100,
    S_PRD = 6'b001000, S_CMP = 6'b010000, S_DONE = 6'b100000
  } st_t;
  st_t st_r;
  logic [33:0] a_r, b_r;
  logic [16:0] n_r, r_r;
  logic [4:0] bit_r;
  logic [2:0] ph_r;
  logic [69:0] tgt_r;
  logic [68:0] acc_r;
  logic [33:0] p_r;
  logic [33:0] cand;
  logic [33:0] mop;
  logic [16:0] mlo;
  logic [50:0] pp;
  assign cand = {17'd0, r_r | (17'd1 << bit_r)};
  always_comb begin
    mop = a_r;
    mlo = a_r[16:0];
    unique case (ph_r)
      3'd0: begin mop = a_r; mlo = a_r[16:0]; end
      3'd1: begin mop = a_r; mlo = a_r[33:17]; end
      3'd2: begin mop = b_r; mlo = b_r[16:0]; end
      3'd3: begin mop = b_r; mlo = b_r[33:17]; end
      3'd4: begin mop = p_r; mlo = p_r[16:0]; end
      default: begin mop = p_r; mlo = p_r[33:17]; end
    endcase
  end
  assign pp = {17'd0, mop} * {34'd0, mlo};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= (st_r == S_DONE);
      unique case (st_r)
        S_IDLE: if (start) begin
          a_r <= sc[33] ? 34'(-sc) : sc;
          b_r <= ss[33] ? 34'(-ss) : ss;
          n_r <= n;
          r_r <= '0;
          bit_r <= 5'd16;
          ph_r <= 3'd0;
          tgt_r <= '0;
          st_r <= S_SQA;
        end
        S_SQA: begin
          tgt_r <= tgt_r + (70'(pp) << (ph_r[0] ? 19 : 2));
          if (ph_r == 3'd3) st_r <= S_TRY;
          ph_r <= ph_r + 3'd1;
        end
        S_TRY: begin
          p_r <= {17'd0, cand[16:0]} * {17'd0, n_r};
          acc_r <= '0;
          ph_r <= 3'd4;
          st_r <= S_PRD;
        end
        S_PRD: begin
          acc_r <= acc_r + (69'(pp) << (ph_r[0] ? 17 : 0));
          if (ph_r == 3'd5) st_r <= S_CMP;
          ph_r <= 3'd5;
        end
        S_CMP: begin
          if ({1'b0, acc_r} <= tgt_r && cand[16:0] <= 17'd65536) r_r <= cand[16:0];
          if (bit_r == 5'd0) st_r <= S_DONE;
          else begin
            bit_r <= bit_r - 5'd1;
            st_r <= S_TRY;
          end
        end
        default: begin
          mag <= r_r;
          st_r <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

/* src/lattice_order_parameter.sv */
// Top level of the lattice order parameter block: phase front end, CORDIC cell chain,
// accumulators and the magnitude unit. Depends on lop_pkg, lop_cordic_cell and lop_isqrt.
//
// Usage: one particle position enters per in_ transfer (x_pos, y_pos in Q16.16, last_point).
// The block takes one point at a time. The two phases are formed, each of them then passes
// the 16-cell CORDIC chain in turn, and the sums are updated. On a point with last_point
// set, the magnitude unit runs a 17-bit square-root search for each magnitude in turn, and
// one result is offered on the out_ channel with both magnitudes, the count and the overflow
// flag. The frame state then clears. While out_stall is high the result holds and no new
// point is taken. cfg_we writes turns_per_unit; the user must do so only while the block is
// idle, as the block itself does not enforce it.
// Reset (rst_n low, synchronous) clears the sums, count, flag and sets turns_per_unit to 1/16.
`timescale 1ns / 1ps
`default_nettype none
module lattice_order_parameter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_x_pos,
  input  wire logic [31:0] in_y_pos,
  input  wire logic        in_last_point,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [16:0]      out_order_first,
  output logic [16:0]      out_order_second,
  output logic [16:0]      out_points_seen,
  output logic             out_count_overflow,
  input  wire logic        cfg_we,
  input  wire logic [23:0] cfg_turns_per_unit
);
  import lop_pkg::*;
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_PRJ = 10'b0000000010, S_PH = 10'b0000000100,
    S_C1 = 10'b0000001000, S_C2 = 10'b0000010000, S_ACC = 10'b0000100000,
    S_M1 = 10'b0001000000, S_M2 = 10'b0010000000, S_OUT = 10'b0100000000,
    S_WAIT = 10'b1000000000
  } st_t;
  st_t st_r;
  logic [23:0] tpu_r;
  logic [31:0] x_r, y_r;
  logic last_r;
  logic [63:0] t_r;
  logic [32:0] a_r, b_r;
  logic [31:0] ph1_r, ph2_r;
  logic [39:0] pa, pb;
  logic [SumW-1:0] sum_r [4];
  logic [CntW-1:0] cnt_r;
  logic ovf_r;
  logic [4:0] k_r;
  logic [15:0] c1_r, s1_r;
  logic [1:0] q_r;
  logic [33:0] cx [CordicSteps+1];
  logic [33:0] cy [CordicSteps+1];
  logic [32:0] cz [CordicSteps+1];
  logic [31:0] phsel, rr;
  logic [1:0] q;
  logic [15:0] cc, sc, co, so;
  logic ms, md;
  logic [33:0] msa, msb;
  logic [16:0] mres;

  assign in_stall = (st_r != S_IDLE);
  assign phsel = (st_r == S_C1) ? ph1_r : ph2_r;
  assign q = 2'(((phsel + 32'h20000000) >> 30));
  assign rr = phsel - {q, 30'd0};
  assign cx[0] = CordicGainQ30;
  assign cy[0] = '0;
  assign cz[0] = {rr[31], rr};
  assign pa = {{7{a_r[32]}}, a_r} * {16'd0, tpu_r};
  assign pb = {{7{b_r[32]}}, b_r} * {16'd0, tpu_r};

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
    lop_cordic_cell u_cell (
      .clk(clk), .step(5'(g)), .en(1'b1),
      .x_in(cx[g]), .y_in(cy[g]), .z_in(cz[g]),
      .x_out(cx[g+1]), .y_out(cy[g+1]), .z_out(cz[g+1])
    );
  end

  function automatic logic [15:0] q15(input logic [33:0] v);
    logic [34:0] r;
    r = $signed({v[33], v} + 35'd16384) >>> 15;
    if ($signed(r) > 35'sd32767) return 16'h7FFF;
    if ($signed(r) < -35'sd32768) return 16'h8000;
    return r[15:0];
  endfunction

  assign cc = q15(cx[CordicSteps]);
  assign sc = q15(cy[CordicSteps]);
  always_comb begin
    unique case (q_r)
      2'd0: begin co = cc; so = sc; end
      2'd1: begin co = 16'(-sc); so = cc; end
      2'd2: begin co = 16'(-cc); so = 16'(-sc); end
      default: begin co = sc; so = 16'(-cc); end
    endcase
  end

  assign ms = (st_r == S_M1 || st_r == S_M2) && k_r == 5'd0;
  assign msa = (st_r == S_M1) ? sum_r[0] : sum_r[2];
  assign msb = (st_r == S_M1) ? sum_r[1] : sum_r[3];
  lop_isqrt u_mag (
    .clk(clk), .rst_n(rst_n), .start(ms), .sc(msa), .ss(msb), .n(cnt_r),
    .done(md), .mag(mres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      tpu_r <= TpuReset;
      for (int i = 0; i < 4; i++) sum_r[i] <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      out_valid <= 1'b0;
      k_r <= '0;
    end else begin
      if (cfg_we) tpu_r <= cfg_turns_per_unit;
      unique case (st_r)
        S_IDLE: if (in_valid) begin
          x_r <= in_x_pos;
          y_r <= in_y_pos;
          last_r <= in_last_point;
          t_r <= $signed(in_y_pos) * $signed({1'b0, InvSqrt3Q32});
          st_r <= S_PRJ;
        end
        S_PRJ: begin
          a_r <= {x_r[31], x_r} + {t_r[63], t_r[63:32]};
          b_r <= {t_r[63:32], 1'b0};
          st_r <= S_PH;
        end
        S_PH: begin
          ph1_r <= pa[39:8];
          ph2_r <= pb[39:8];
          k_r <= '0;
          st_r <= (cnt_r < CntW'(MaxPoints)) ? S_C1 : S_ACC;
          if (cnt_r >= CntW'(MaxPoints)) ovf_r <= 1'b1;
        end
        S_C1: begin
          if (k_r == 5'd0) q_r <= q;
          if (k_r == 5'(CordicSteps)) begin
            c1_r <= co;
            s1_r <= so;
            k_r <= '0;
            st_r <= S_C2;
          end else begin
            k_r <= k_r + 5'd1;
          end
        end
        S_C2: begin
          if (k_r == 5'd0) q_r <= q;
          if (k_r == 5'(CordicSteps)) begin
            sum_r[0] <= sum_r[0] + SumW'($signed(c1_r));
            sum_r[1] <= sum_r[1] + SumW'($signed(s1_r));
            sum_r[2] <= sum_r[2] + SumW'($signed(co));
            sum_r[3] <= sum_r[3] + SumW'($signed(so));
            cnt_r <= cnt_r + 1'b1;
            k_r <= '0;
            st_r <= S_ACC;
          end else begin
            k_r <= k_r + 5'd1;
          end
        end
        S_ACC: begin
          k_r <= '0;
          st_r <= last_r ? S_M1 : S_IDLE;
        end
        S_M1: begin
          if (md) begin
            out_order_first <= mres;
            k_r <= '0;
            st_r <= S_M2;
          end else begin
            k_r <= 5'd1;
          end
        end
        S_M2: begin
          k_r <= 5'd1;
          if (md) begin
            out_order_second <= mres;
            out_points_seen <= cnt_r;
            out_count_overflow <= ovf_r;
            out_valid <= 1'b1;
            st_r <= S_OUT;
          end
        end
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          for (int i = 0; i < 4; i++) sum_r[i] <= '0;
          cnt_r <= '0;
          ovf_r <= 1'b0;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* tb/lattice_order_parameter_test.sv */
// Self-checking testbench for lattice_order_parameter: per-point phase and CORDIC prediction,
// frame magnitudes checked against every out_ transfer. Depends on lop_pkg and the block's RTL.
`timescale 1ns / 1ps
module lattice_order_parameter_test;
  import lop_pkg::*;

  typedef struct packed {
    logic [16:0] order_first;
    logic [16:0] order_second;
    logic [16:0] points_seen;
    logic        count_overflow;
  } frame_result_t;

  localparam longint AtanTurns [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] in_x_pos = '0;
  logic [31:0] in_y_pos = '0;
  logic in_last_point = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [16:0] out_order_first;
  logic [16:0] out_order_second;
  logic [16:0] out_points_seen;
  logic out_count_overflow;
  logic cfg_we = 1'b0;
  logic [23:0] cfg_turns_per_unit = '0;

  logic [23:0] model_turns;
  longint frame_sums [4];
  int unsigned frame_count;
  logic frame_overflow;
  frame_result_t pending_frames[$];
  int fail_count = 0;
  int points_sent = 0;
  int frames_checked = 0;
  bit idling_on = 1'b1;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;

  lattice_order_parameter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_x_pos(in_x_pos), .in_y_pos(in_y_pos),
    .in_last_point(in_last_point),
    .out_valid(out_valid), .out_stall(out_stall), .out_order_first(out_order_first),
    .out_order_second(out_order_second), .out_points_seen(out_points_seen),
    .out_count_overflow(out_count_overflow),
    .cfg_we(cfg_we), .cfg_turns_per_unit(cfg_turns_per_unit)
  );

  always #4 clk = ~clk;

  function automatic int round_q15(longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return int'(r);
  endfunction

  function automatic void rotate_phase(input logic [31:0] ph, output int c, output int s);
    logic [1:0] quad;
    logic [31:0] resid;
    longint z, x, y, dx, dy;
    int cc, ss;
    quad = 2'((ph + 32'h20000000) >> 30);
    resid = ph - {quad, 30'b0};
    z = longint'($signed(resid));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTurns[i];
      end else begin
        x += dx; y -= dy; z += AtanTurns[i];
      end
    end
    cc = round_q15(x);
    ss = round_q15(y);
    case (quad)
      2'd0: begin c = cc; s = ss; end
      2'd1: begin c = -ss; s = cc; end
      2'd2: begin c = -cc; s = -ss; end
      default: begin c = ss; s = -cc; end
    endcase
  endfunction

  function automatic logic [16:0] frame_magnitude(longint sc, longint sn, int unsigned n);
    logic [127:0] abs_c, abs_s, bound, p;
    int unsigned lo, hi, mid;
    abs_c = (sc < 0) ? -sc : sc;
    abs_s = (sn < 0) ? -sn : sn;
    bound = (abs_c * abs_c + abs_s * abs_s) << 2;
    lo = 0;
    hi = 65536;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      p = 128'(mid) * 128'(n);
      if (p * p <= bound) lo = mid;
      else hi = mid - 1;
    end
    return 17'(lo);
  endfunction

  function automatic void clear_frame();
    for (int i = 0; i < 4; i++) frame_sums[i] = 0;
    frame_count = 0;
    frame_overflow = 1'b0;
  endfunction

  function automatic void accumulate_point(logic [31:0] xp, logic [31:0] yp, logic last);
    logic [63:0] xs, ys, prod, yq, a, b, pa, pb;
    int c1, s1, c2, s2;
    frame_result_t res;
    xs = {{32{xp[31]}}, xp};
    ys = {{32{yp[31]}}, yp};
    prod = ys * {32'b0, InvSqrt3Q32};
    yq = {{32{ys[63]}}, prod[63:32]};
    a = xs + yq;
    b = yq + yq;
    pa = a * {40'b0, model_turns};
    pb = b * {40'b0, model_turns};
    if (frame_count < MaxPoints) begin
      rotate_phase(pa[39:8], c1, s1);
      rotate_phase(pb[39:8], c2, s2);
      frame_sums[0] += c1;
      frame_sums[1] += s1;
      frame_sums[2] += c2;
      frame_sums[3] += s2;
      frame_count++;
    end else begin
      frame_overflow = 1'b1;
    end
    if (last) begin
      res.order_first = frame_magnitude(frame_sums[0], frame_sums[1], frame_count);
      res.order_second = frame_magnitude(frame_sums[2], frame_sums[3], frame_count);
      res.points_seen = (frame_count > 131071) ? 17'h1FFFF : 17'(frame_count);
      res.count_overflow = frame_overflow;
      pending_frames.push_back(res);
      clear_frame();
    end
  endfunction

  task automatic send_point(logic [31:0] xp, logic [31:0] yp, logic last);
    if (idling_on) begin
      while ($urandom_range(99) < 23) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_x_pos <= xp;
    in_y_pos <= yp;
    in_last_point <= last;
    do @(posedge clk); while (in_stall);
    accumulate_point(xp, yp, last);
    points_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_turns(logic [23:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_turns_per_unit <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_turns = value;
  endtask

  function automatic logic [31:0] random_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return 32'($signed($urandom_range(2 * 65536 * 1024)) - 65536 * 1024);
    endcase
  endfunction

  task automatic test_extremes();
    logic [31:0] edges [5] = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h00010000};
    foreach (edges[i]) send_point(edges[i], edges[4 - i], 1'b1);
    send_point(32'h00010000, 32'h0, 1'b0);
    send_point(32'h0, 32'h00010000, 1'b0);
    send_point(32'h7FFFFFFF, 32'h80000000, 1'b1);
    write_turns(24'h000000);
    send_point(32'h12345678, 32'h9ABCDEF0, 1'b0);
    send_point(32'h80000000, 32'h7FFFFFFF, 1'b1);
    write_turns(24'hFFFFFF);
    foreach (edges[i]) send_point(edges[i], edges[i], i == 4);
    send_point(32'hFFFFFFFF, 32'h80000000, 1'b1);
    write_turns(TpuReset);
  endtask

  task automatic test_random_frames();
    int sent;
    int frame_len;
    sent = 0;
    while (sent < 1920) begin
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0: write_turns(24'h000000);
          1: write_turns(24'hFFFFFF);
          default: write_turns(24'($urandom()));
        endcase
      end
      idling_on = !(sent >= 600 && sent < 900);
      frame_len = ($urandom_range(3) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
      for (int i = 0; i < frame_len; i++) begin
        send_point(random_coord(), random_coord(), i == frame_len - 1);
        sent++;
      end
    end
    idling_on = 1'b1;
  endtask

  task automatic test_output_hold();
    wait_idle();
    hold_token++;
    for (int i = 0; i < 12; i++) send_point(random_coord(), random_coord(), i % 3 != 1);
  endtask

  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= 3000;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idling_on && ($urandom_range(99) < 23);
    end
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected result transfer");
        fail_count++;
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        if (out_order_first !== want.order_first) begin
          $error("order_first expected %0d actual %0d", want.order_first, out_order_first);
          fail_count++;
        end
        if (out_order_second !== want.order_second) begin
          $error("order_second expected %0d actual %0d", want.order_second, out_order_second);
          fail_count++;
        end
        if (out_points_seen !== want.points_seen) begin
          $error("points_seen expected %0d actual %0d", want.points_seen, out_points_seen);
          fail_count++;
        end
        if (out_count_overflow !== want.count_overflow) begin
          $error("count_overflow expected %0d actual %0d", want.count_overflow,
                 out_count_overflow);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #250_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    model_turns = TpuReset;
    clear_frame();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_random_frames();
    test_output_hold();
    wait_idle();
    if (pending_frames.size() != 0) fail_count++;
    $display("Sent %0d points and checked %0d frame results, covering random frames,",
             points_sent, frames_checked);
    $display("extreme coordinates and scales, and a long output hold.");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

/* filelist.f */
src/lop_pkg.sv
src/lop_cordic_cell.sv
src/lop_isqrt.sv
src/lattice_order_parameter.sv
tb/lattice_order_parameter_test.sv
